// ===== sv/bss_pkg.sv =====
// bss_pkg: request kinds, result status codes and field widths for the
// bounded stack with search. No dependencies.
package bss_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_SEARCH  = 2'd2,
    KIND_DISPLAY = 2'd3
  } bss_kind_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_POPPED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_ELEMENT   = 3'd6,
    ST_EMPTY     = 3'd7
  } bss_status_e;

  typedef logic signed [WordW-1:0] bss_word_t;

endpackage

// ===== sv/bss_if.sv =====
// bss_if: valid/ready channels for stack requests and results.
// Depends on bss_pkg.
interface bss_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  bss_pkg::bss_word_t  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bss_rsp_if;
  logic                  valid;
  logic                  ready;
  bss_pkg::bss_status_e  status;
  bss_pkg::bss_word_t    data;
  logic                  last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== sv/bss_ram.sv =====
// bss_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/bounded_stack_with_search_unit.sv =====
// Push is handled on acceptance. Pop does one RAM read. Search compares
// one entry per cycle from the top. Display emits one element per cycle
// while the result side does not stall. One request at a time.
// Reset (async, active low) empties the stack and drops any pending result;
// the entry RAM is not cleared.
// bounded_stack_with_search_unit: top level, uses bss_pkg, bss_if, bss_ram.
module bounded_stack_with_search_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bss_req_if.sink     req_i,
  bss_rsp_if.source   rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DISP = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d, cnt_m1;
  logic [AW-1:0]        idx_q, idx_d, raddr;
  bss_pkg::bss_word_t   key_q, key_d;
  bss_pkg::bss_word_t   rdata;
  logic                 we;
  logic                 slot_free, accept;

  logic                 emit;
  bss_pkg::bss_status_e e_status;
  bss_pkg::bss_word_t   e_data;
  logic                 e_last;

  logic                 rsp_valid_q;
  bss_pkg::bss_status_e status_q;
  bss_pkg::bss_word_t   data_q;
  logic                 last_q;

  assign cnt_m1    = cnt_q - CW'(1);
  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept    = req_i.valid && req_i.ready;

  bss_ram #(
    .WIDTH (bss_pkg::WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (req_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    key_d    = key_q;
    we       = 1'b0;
    emit     = 1'b0;
    e_status = bss_pkg::ST_PUSHED;
    e_data   = '0;
    e_last   = 1'b1;
    raddr    = (state_q == S_IDLE) ? cnt_m1[AW-1:0] : idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = req_i.value;
          idx_d = cnt_m1[AW-1:0];
          unique case (bss_pkg::bss_kind_e'(req_i.req_type))
            bss_pkg::KIND_PUSH: begin
              emit = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                e_status = bss_pkg::ST_OVERFLOW;
              end else begin
                we       = 1'b1;
                cnt_d    = cnt_q + CW'(1);
                e_status = bss_pkg::ST_PUSHED;
              end
            end
            bss_pkg::KIND_POP: begin
              if (cnt_q == '0) begin
                emit     = 1'b1;
                e_status = bss_pkg::ST_UNDERFLOW;
              end else begin
                cnt_d   = cnt_m1;
                state_d = S_POP;
              end
            end
            bss_pkg::KIND_SEARCH: begin
              if (cnt_q == '0) begin
                emit     = 1'b1;
                e_status = bss_pkg::ST_NOTFOUND;
              end else begin
                state_d = S_SRCH;
              end
            end
            bss_pkg::KIND_DISPLAY: begin
              if (cnt_q == '0) begin
                emit     = 1'b1;
                e_status = bss_pkg::ST_EMPTY;
              end else begin
                state_d = S_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        emit     = 1'b1;
        e_status = bss_pkg::ST_POPPED;
        e_data   = rdata;
        state_d  = S_IDLE;
      end
      S_SRCH: begin
        if (rdata == key_q) begin
          emit     = 1'b1;
          e_status = bss_pkg::ST_FOUND;
          state_d  = S_IDLE;
        end else if (idx_q == '0) begin
          emit     = 1'b1;
          e_status = bss_pkg::ST_NOTFOUND;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_q - AW'(1);
          raddr = idx_d;
        end
      end
      S_DISP: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_status = bss_pkg::ST_ELEMENT;
          e_data   = rdata;
          e_last   = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q - AW'(1);
            raddr = idx_d;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    if (emit) begin
      status_q <= e_status;
      data_q   <= e_data;
      last_q   <= e_last;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.data   = data_q;
  assign rsp_o.last   = last_q;

endmodule
